FILE: rtl/chd_pkg.sv
package chd_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int STEP_W = $clog2(CORDIC_ITERS + 1);
	localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
	localparam int ATAN_W = 16;

	localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
		16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2,
		16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
	};

	localparam int MAG_W = 16;
	localparam int PRESCALE_SH = 8;
	localparam int XY_W = 26;
	localparam int Z_W = 20;
	localparam logic signed [Z_W-1:0] PI_Q16 = 20'sd205887;

	localparam int ANG_W = 21;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q16 = 21'sd411775;
	localparam int WRAP_W = 19;

	localparam int DPR_W = 22;
	localparam logic [DPR_W-1:0] DEG_PER_RAD = 22'd3754936;
	localparam int PROD_W = WRAP_W + DPR_W;
	localparam int DEG_FRAC_W = 32;

	localparam int N_W = 16;
	localparam logic [7:0] REMAP_MUL = 8'd179;
	localparam int RECIP_W = 17;
	localparam logic [RECIP_W-1:0] RECIP_239 = 17'd70198;
	localparam int RECIP_SH = 24;
	localparam int RECIP_PROD_W = N_W + RECIP_W;

	localparam int HEADING_W = 9;
	localparam logic [HEADING_W-1:0] LOW_END = 9'd240;
	localparam logic [HEADING_W-1:0] HI_BASE = 9'd180;

	localparam int DECL_W = 19;
	localparam int BAND_W = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 19;
	localparam logic [CFG_INDEX_W-1:0] REG_DECLINATION = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 1'b1;
	localparam logic signed [DECL_W-1:0] DECL_RESET = 19'sd590;
	localparam logic [BAND_W-1:0] BAND_RESET = 4'd3;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [MAG_W-1:0] mag_x;
		logic signed [MAG_W-1:0] mag_y;
	} in_item_t;

	typedef struct packed {
		logic [HEADING_W-1:0] heading_degrees;
		logic held;
	} out_item_t;

	typedef struct packed {
		logic signed [DECL_W-1:0] declination_offset;
		logic [BAND_W-1:0] deadband_degrees;
	} cfg_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0] z;
		logic zero;
	} front_item_t;

	typedef struct packed {
		logic signed [Z_W-1:0] z;
	} cordic_res_t;

endpackage

FILE: rtl/compass_heading_deadband.sv
// Throughput is set by the shared iterative CORDIC rotation unit: it loads an item, then
// performs one micro-rotation per cycle and accepts the next item only as its result is taken.
// A two-entry queue decouples input classification from the CORDIC and post pipeline.
// Reset clears all handshake state, sets declination to 590 and deadband to 3,
// and clears the last reported heading to 0.
module compass_heading_deadband import chd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input in_item_t in_data,
	input logic in_valid,
	output logic in_ready,
	output out_item_t out_data,
	output logic out_valid,
	input logic out_ready,
	input logic cfg_wr_en,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	front_item_t front_item;
	logic front_valid;
	logic front_ready;
	front_item_t queue_item;
	logic queue_valid;
	logic queue_ready;
	cordic_res_t cordic_res;
	logic cordic_valid;
	logic cordic_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.declination_offset <= DECL_RESET;
			cfg_q.deadband_degrees <= BAND_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DECLINATION: cfg_q.declination_offset <= signed'(cfg_data[DECL_W-1:0]);
				REG_DEADBAND: cfg_q.deadband_degrees <= cfg_data[BAND_W-1:0];
			endcase
		end
	end

	chd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.item(front_item),
		.item_valid(front_valid),
		.item_ready(front_ready)
	);

	chd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(front_item),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.pop_data(queue_item),
		.pop_valid(queue_valid),
		.pop_ready(queue_ready)
	);

	chd_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.item(queue_item),
		.item_valid(queue_valid),
		.item_ready(queue_ready),
		.res(cordic_res),
		.res_valid(cordic_valid),
		.res_ready(cordic_ready)
	);

	chd_post u_post (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.res(cordic_res),
		.res_valid(cordic_valid),
		.res_ready(cordic_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

endmodule

FILE: rtl/chd_front.sv
module chd_front import chd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input in_item_t in_data,
	input logic in_valid,
	output logic in_ready,
	output front_item_t item,
	output logic item_valid,
	input logic item_ready
);

	logic vld_s1;
	front_item_t item_s1;
	front_item_t cls;
	logic signed [XY_W-1:0] xw;
	logic signed [XY_W-1:0] yw;
	logic x_neg;

	assign in_ready = !vld_s1 || item_ready;
	assign item_valid = vld_s1;
	assign item = item_s1;

	always_comb begin
		x_neg = in_data.mag_x < 0;
		xw = XY_W'(in_data.mag_x) <<< PRESCALE_SH;
		yw = XY_W'(in_data.mag_y) <<< PRESCALE_SH;
		cls.x = x_neg ? -xw : xw;
		cls.y = x_neg ? -yw : yw;
		if (x_neg) begin
			cls.z = (in_data.mag_y >= 0) ? PI_Q16 : -PI_Q16;
		end else begin
			cls.z = '0;
		end
		cls.zero = (in_data.mag_x == '0) && (in_data.mag_y == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule

FILE: rtl/chd_queue.sv
module chd_queue import chd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input front_item_t push_data,
	input logic push_valid,
	output logic push_ready,
	output front_item_t pop_data,
	output logic pop_valid,
	input logic pop_ready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	front_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/chd_cordic.sv
module chd_cordic import chd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input front_item_t item,
	input logic item_valid,
	output logic item_ready,
	output cordic_res_t res,
	output logic res_valid,
	input logic res_ready
);

	logic busy_q;
	logic [STEP_W-1:0] step_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0] z_q;
	logic zero_q;

	logic finished;
	logic load;
	logic iterate;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0] atan_ext;

	assign finished = step_q == STEP_W'(CORDIC_ITERS);
	assign res_valid = busy_q && finished;
	assign item_ready = !busy_q || (finished && res_ready);
	assign load = item_valid && item_ready;
	assign iterate = busy_q && !finished;
	assign res.z = zero_q ? '0 : z_q;

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		atan_ext = signed'(Z_W'(ATAN_TAB[ATAN_IDX_W'(step_q)]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (iterate) begin
			step_q <= step_q + 1'b1;
		end else if (res_valid && res_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= item.x;
			y_q <= item.y;
			z_q <= item.z;
			zero_q <= item.zero;
		end else if (iterate) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_ext;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_ext;
			end
		end
	end

endmodule

FILE: rtl/chd_post.sv
module chd_post import chd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input cordic_res_t res,
	input logic res_valid,
	output logic res_ready,
	output out_item_t out_data,
	output logic out_valid,
	input logic out_ready
);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [ANG_W-1:0] ang_s1;
	logic signed [ANG_W-1:0] ang_s2;
	logic [WRAP_W-1:0] ang_s3;
	logic [PROD_W-1:0] prod_s4;
	logic [HEADING_W-1:0] deg_s5;
	logic half_s5;
	logic [N_W-1:0] num_s5;
	logic [HEADING_W-1:0] deg_s6;
	logic half_s6;
	logic [HEADING_W-1:0] quo_s6;
	out_item_t out_s7;
	logic [HEADING_W-1:0] last_heading_q;

	logic signed [ANG_W-1:0] ang2_d;
	logic signed [ANG_W-1:0] ang3_d;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [HEADING_W-1:0] hi_off;
	logic [HEADING_W-1:0] hi_scaled;
	logic [HEADING_W-1:0] heading;
	logic [HEADING_W:0] h_ext;
	logic [HEADING_W:0] p_ext;
	logic [HEADING_W:0] b_ext;
	logic in_band;
	out_item_t result;

	assign en = !vld_s7 || out_ready;
	assign res_ready = en;
	assign out_valid = vld_s7;
	assign out_data = out_s7;

	always_comb begin
		if (ang_s1 < 0) begin
			ang2_d = ang_s1 + TWO_PI_Q16;
		end else if (ang_s1 >= TWO_PI_Q16) begin
			ang2_d = ang_s1 - TWO_PI_Q16;
		end else begin
			ang2_d = ang_s1;
		end
		ang3_d = (ang_s2 < 0) ? ang_s2 + TWO_PI_Q16 : ang_s2;
		recip_prod = RECIP_PROD_W'(num_s5) * RECIP_PROD_W'(RECIP_239);
	end

	always_comb begin
		hi_off = deg_s6 - LOW_END;
		hi_scaled = (hi_off + (hi_off << 1)) >> 1;
		priority if (deg_s6 >= LOW_END) begin
			heading = hi_scaled + HI_BASE;
		end else if (deg_s6 != '0) begin
			heading = quo_s6;
		end else begin
			heading = HEADING_W'(half_s6);
		end
		h_ext = {1'b0, heading};
		p_ext = {1'b0, last_heading_q};
		b_ext = (HEADING_W + 1)'(cfg.deadband_degrees);
		in_band = (h_ext < p_ext + b_ext) && (h_ext + b_ext > p_ext);
		result.heading_degrees = in_band ? last_heading_q : heading;
		result.held = in_band;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			last_heading_q <= '0;
		end else if (en) begin
			vld_s1 <= res_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			if (vld_s6) begin
				last_heading_q <= result.heading_degrees;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ANG_W'(res.z) + ANG_W'(cfg.declination_offset);
			ang_s2 <= ang2_d;
			ang_s3 <= WRAP_W'(ang3_d);
			prod_s4 <= PROD_W'(ang_s3) * PROD_W'(DEG_PER_RAD);
			deg_s5 <= prod_s4[PROD_W-1:DEG_FRAC_W];
			half_s5 <= prod_s4[DEG_FRAC_W-1];
			num_s5 <= N_W'(N_W'(prod_s4[PROD_W-1:DEG_FRAC_W]) * N_W'(REMAP_MUL));
			deg_s6 <= deg_s5;
			half_s6 <= half_s5;
			quo_s6 <= recip_prod[RECIP_SH +: HEADING_W];
			out_s7 <= result;
		end
	end

endmodule

FILE: tb/compass_heading_deadband_chk.sv
`timescale 1ns / 1ps

module compass_heading_deadband_chk import chd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input in_item_t in_data,
	input logic in_valid,
	input logic in_ready,
	input out_item_t out_data,
	input logic out_valid,
	input logic out_ready,
	input logic cfg_wr_en,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int errors,
	output int pending
);

	localparam longint FULL_TURN = longint'(TWO_PI_Q16);
	localparam longint HALF_TURN = longint'(PI_Q16);
	localparam longint RAD_TO_DEG = longint'(DEG_PER_RAD);
	localparam longint LOW_SPAN = 239;
	localparam longint LOW_SCALE = 179;
	localparam longint HIGH_START = 240;
	localparam longint HIGH_BASE = 180;
	localparam longint HIGH_SCALE = 180;
	localparam longint HIGH_SPAN = 120;

	longint decl_q16;
	longint band_deg;
	longint last_heading;
	int fail_cnt;
	out_item_t heading_q[$];

	function automatic longint cordic_angle(longint y_in, longint x_in);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		z = 0;
		if (x_in == 0 && y_in == 0)
			return 0;
		x = x_in * 256;
		y = y_in * 256;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(ATAN_TAB[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic out_item_t predict_heading(in_item_t s);
		longint ang;
		longint degq;
		longint d;
		longint hd;
		out_item_t r;
		ang = cordic_angle(longint'(s.mag_y), longint'(s.mag_x)) + decl_q16;
		ang = ang % FULL_TURN;
		if (ang < 0)
			ang = ang + FULL_TURN;
		degq = (ang * RAD_TO_DEG) >>> 16;
		d = degq >>> 16;
		if (d >= 1 && d < HIGH_START)
			hd = d * LOW_SCALE / LOW_SPAN;
		else if (d >= HIGH_START)
			hd = (d - HIGH_START) * HIGH_SCALE / HIGH_SPAN + HIGH_BASE;
		else
			hd = (degq >= 32768) ? 1 : 0;
		r.held = 1'b0;
		if (hd < last_heading + band_deg && hd > last_heading - band_deg) begin
			hd = last_heading;
			r.held = 1'b1;
		end
		last_heading = hd & 'h1FF;
		r.heading_degrees = hd[HEADING_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q16 = longint'(DECL_RESET);
			band_deg = longint'(BAND_RESET);
			last_heading = 0;
			fail_cnt = 0;
			heading_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DECLINATION: decl_q16 = longint'($signed(cfg_data[DECL_W-1:0]));
					REG_DEADBAND: band_deg = longint'(cfg_data[BAND_W-1:0]);
				endcase
			end
			if (out_valid && out_ready) begin
				if (heading_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual heading %0d held %0b",
						$time, out_data.heading_degrees, out_data.held);
					fail_cnt++;
				end else begin
					out_item_t want;
					want = heading_q.pop_front();
					if (want.heading_degrees !== out_data.heading_degrees) begin
						$display("%0t: heading_degrees mismatch, expected %0d, actual %0d",
							$time, want.heading_degrees, out_data.heading_degrees);
						fail_cnt++;
					end
					if (want.held !== out_data.held) begin
						$display("%0t: held mismatch, expected %0b, actual %0b",
							$time, want.held, out_data.held);
						fail_cnt++;
					end
				end
			end
			if (in_valid && in_ready)
				heading_q.push_back(predict_heading(in_data));
			pending <= heading_q.size();
			errors <= fail_cnt;
		end
	end

endmodule

FILE: tb/compass_heading_deadband_tb.sv
`timescale 1ns / 1ps

module compass_heading_deadband_tb;
	import chd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	in_item_t in_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	out_item_t out_data;
	logic out_valid;
	logic out_ready = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int ready_mode = 0;
	int mode_left = 0;
	in_item_t prev_sample = '0;

	compass_heading_deadband i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	compass_heading_deadband_chk i_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: switch at random between stall styles for out_ready
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(10, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ~out_ready;
		endcase
	end

	function automatic in_item_t mk_sample(int x, int y);
		in_item_t s;
		s.mag_x = MAG_W'(x);
		s.mag_y = MAG_W'(y);
		return s;
	endfunction

	function automatic logic [MAG_W-1:0] edge_value();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			default: return 16'h0000;
		endcase
	endfunction

	function automatic in_item_t next_sample();
		in_item_t s;
		case ($urandom_range(0, 9))
			0: s = mk_sample(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
			1, 2, 3: begin
				// drift around the last sample so the deadband gets exercised
				s.mag_x = prev_sample.mag_x + MAG_W'(int'($urandom_range(0, 200)) - 100);
				s.mag_y = prev_sample.mag_y + MAG_W'(int'($urandom_range(0, 200)) - 100);
			end
			4: begin
				s.mag_x = edge_value();
				s.mag_y = ($urandom_range(0, 1) == 1) ? edge_value() : MAG_W'($urandom);
			end
			default: s = in_item_t'($urandom);
		endcase
		return s;
	endfunction

	task automatic send_sample(in_item_t s);
		in_data <= s;
		in_valid <= 1'b1;
		prev_sample = s;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic [DECL_W-1:0] decl, logic [BAND_W-1:0] band);
		logic [CFG_DATA_W-BAND_W-1:0] pad;
		pad = (CFG_DATA_W - BAND_W)'($urandom);
		write_reg(REG_DECLINATION, decl);
		write_reg(REG_DEADBAND, {pad, band});
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed_samples();
		send_sample(mk_sample(0, 0));
		send_sample(mk_sample(32767, 0));
		send_sample(mk_sample(32767, 0));
		send_sample(mk_sample(-32768, 0));
		send_sample(mk_sample(0, 32767));
		send_sample(mk_sample(0, -32768));
		send_sample(mk_sample(32767, 32767));
		send_sample(mk_sample(-32768, -32768));
		send_sample(mk_sample(-32768, 32767));
		send_sample(mk_sample(32767, -32768));
		send_sample(mk_sample(-1, 0));
		send_sample(mk_sample(-1, -1));
		send_sample(mk_sample(-1, 1));
		send_sample(mk_sample(1, -1));
		send_sample(mk_sample(0, 1));
		send_sample(mk_sample(0, -1));
		send_sample(mk_sample(1, 0));
		send_sample(mk_sample(32767, 1));
		send_sample(mk_sample(32767, -1));
		send_sample(mk_sample(-32768, -1));
		send_sample(mk_sample(20000, -200));
		send_sample(mk_sample(20000, 200));
		send_sample(mk_sample(-5, 3));
	endtask

	task automatic random_samples(int count);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && left > 0; k++) begin
				send_sample(next_sample());
				left--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				in_data <= in_item_t'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_samples();
		drain();
		set_config('0, '0);
		directed_samples();

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			case (ph)
				0: set_config(19'h3FFFF, 4'd15);
				1: set_config(19'h40000, 4'd1);
				2: set_config(DECL_W'(205887), 4'd7);
				3: set_config(DECL_W'(-205887), 4'd3);
				default: set_config(DECL_W'($urandom), BAND_W'($urandom));
			endcase
			random_samples(280);
		end
		drain();

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
